// ===== rtl/core/nrrc_pkg.sv =====
// Shared constants, types and the part-to-offset map of the note release rate calculator.
`default_nettype none

package nrrc_pkg;

   localparam int PART_COUNT   = 10;
   localparam int OFFSET_COUNT = 8;
   localparam int INC_W        = 9;

   localparam logic [6:0] NOTE_FLOOR = 7'h15;
   localparam logic [7:0] BASE_MUL   = 8'h76;
   localparam logic [7:0] INC_MUL_A  = 8'h97;
   localparam logic [6:0] INC_MUL_B  = 7'h6D;
   localparam logic [6:0] INC_SPLIT  = 7'h1B;
   localparam logic [INC_W-1:0] INC_HIGH = 9'h0DB;

   // Offset used by each part; parts 8 and 9 share offset 0.
   localparam logic [2:0] PART_SEL [PART_COUNT] = '{
      3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7, 3'd0, 3'd0
   };

   typedef logic [PART_COUNT-1:0][7:0]   part_arr_type;
   typedef logic [OFFSET_COUNT-1:0][7:0] off_arr_type;

   typedef struct packed {
      logic [3:0]       voice;
      logic [7:0]       base;
      logic [INC_W-1:0] inc;
      part_arr_type     parts;
   } front_out_type;

endpackage

`default_nettype wire

// ===== rtl/core/note_release_rate_calc_top.sv =====
// Top level of the note release rate calculator: ports, lanes and checks.
//
//  channel   | direction | handshake              | payload
//  ----------+-----------+------------------------+-------------------------------------
//  req       | in        | req_tvalid/req_tready  | voice_index, note, part0..9 base
//  rsp       | out       | rsp_tvalid/rsp_tready  | voice_out, speed0..speed9
//  csr       | in        | csr_wr_en              | release scale
//
//  A req transaction passes through note scaling, base/increment multipliers,
//  then lanes plus saturating merge into the output register. One
//  transaction per cycle is sustained while rsp_tready stays high; the 8x8
//  and 8x7 multiplies of the second stage set the clock. Every stage holds
//  its data while the next one is full, so a stalled rsp only fills the pipe
//  ahead of it. Synchronous reset empties the pipe and clears the release scale.
`default_nettype none

module note_release_rate_calc_top
   import nrrc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [3:0] voice_index, [10:4] note, [18:11] part0_base ... [90:83] part9_base, [95:91] zero
   input  wire logic [95:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [3:0] voice_out, [11:4] speed0 ... [83:76] speed9, [87:84] zero
   output logic [87:0]      rsp_tdata,
   input  wire logic        csr_wr_en,
   input  wire logic [7:0]  csr_wr_data
);

   logic [7:0]    rel_scale_ff;
   part_arr_type  req_parts;
   logic          front_valid;
   logic          merge_ready;
   front_out_type front_data;
   off_arr_type   offsets;
   logic [3:0]    rsp_voice;
   part_arr_type  rsp_speeds;

   // Release scale register; the user must write it only while the pipe is idle, the block does not enforce this.
   always_ff @(posedge clock) begin
      if (reset) begin
         rel_scale_ff <= 8'd0;
      end else if (csr_wr_en) begin
         rel_scale_ff <= csr_wr_data;
      end
   end

   // Unpack part bases from the request data.
   always_comb begin
      for (int p = 0; p < PART_COUNT; p++) begin
         req_parts[p] = req_tdata[11 + 8*p +: 8];
      end
   end

   nrrc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_voice  (req_tdata[3:0]),
      .in_note   (req_tdata[10:4]),
      .in_parts  (req_parts),
      .rel_scale (rel_scale_ff),
      .out_valid (front_valid),
      .out_ready (merge_ready),
      .out_data  (front_data)
   );

   // One lane per offset; all eight work on the same transaction.
   for (genvar i = 0; i < OFFSET_COUNT; i++) begin : g_lane
      nrrc_lane #(
         .LANE_INDEX (i)
      ) u_lane (
         .base   (front_data.base),
         .inc    (front_data.inc),
         .offset (offsets[i])
      );
   end

   nrrc_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (front_valid),
      .in_ready   (merge_ready),
      .in_voice   (front_data.voice),
      .in_parts   (front_data.parts),
      .in_offsets (offsets),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_voice  (rsp_voice),
      .out_speeds (rsp_speeds)
   );

   // Pack the response: voice in the low nibble, speeds upward, pad with zeros.
   assign rsp_tdata = {4'd0, rsp_speeds, rsp_voice};

   // An empty output register must let every earlier stage drain.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request stalled while output register empty");

   // Nothing is presented right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // The increment never exceeds the high-note constant.
   a_inc_range: assert property (@(posedge clock) disable iff (reset)
      front_valid |-> (front_data.inc <= INC_HIGH))
      else $error("increment out of range");

   // Zero base and increment (low notes) must give all-zero offsets.
   a_low_offsets: assert property (@(posedge clock) disable iff (reset)
      (front_valid && front_data.base == 8'd0 && front_data.inc == '0)
         |-> (offsets == '0))
      else $error("nonzero offset for zero base and increment");

endmodule

`default_nettype wire

// ===== rtl/core/nrrc_front.sv =====
// Two-stage front end: note scaling, then base and increment products.
`default_nettype none

module nrrc_front
   import nrrc_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          in_valid,
   output logic               in_ready,
   input  wire logic [3:0]    in_voice,
   input  wire logic [6:0]    in_note,
   input  wire part_arr_type  in_parts,
   input  wire logic [7:0]    rel_scale,
   output logic               out_valid,
   input  wire logic          out_ready,
   output front_out_type      out_data
);

   logic         low;
   logic [6:0]   nb;
   logic [13:0]  prod_a;
   logic [12:0]  prod_b;
   logic         ready1;
   logic         ready2;

   logic         s1_v_ff, s1_v_in;
   logic [3:0]   s1_voice_ff;
   logic         s1_low_ff;
   logic         s1_hinc_ff;
   logic [7:0]   s1_h_ff;
   logic [7:0]   s1_t_ff;
   part_arr_type s1_parts_ff;

   logic [15:0]      bprod;
   logic [14:0]      iprod;
   logic             s2_v_ff, s2_v_in;
   front_out_type    s2_ff, s2_in;

   // Stage 1: note offset and constant products.
   assign low    = in_note < NOTE_FLOOR;
   assign nb     = in_note - NOTE_FLOOR;
   assign prod_a = {7'd0, nb} * {6'd0, BASE_MUL};
   assign prod_b = {8'd0, nb[4:0]} * {5'd0, INC_MUL_A};

   assign ready2   = !s2_v_ff || out_ready;
   assign ready1   = !s1_v_ff || ready2;
   assign in_ready = ready1;

   assign s1_v_in = ready1 ? in_valid : s1_v_ff;
   assign s2_v_in = ready2 ? s1_v_ff : s2_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= s1_v_in;
         s2_v_ff <= s2_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && ready1) begin
         s1_voice_ff <= in_voice;
         s1_low_ff   <= low;
         s1_hinc_ff  <= nb >= INC_SPLIT;
         s1_h_ff     <= prod_a[13:6];
         s1_t_ff     <= prod_b[12:5];
         s1_parts_ff <= in_parts;
      end
   end

   // Stage 2: scale by the release parameter and form the increment.
   assign bprod = {8'd0, s1_h_ff} * {8'd0, rel_scale};
   assign iprod = {7'd0, s1_t_ff} * {8'd0, INC_MUL_B};

   always_comb begin
      s2_in.voice = s1_voice_ff;
      s2_in.parts = s1_parts_ff;
      if (s1_low_ff) begin
         s2_in.base = 8'd0;
         s2_in.inc  = '0;
      end else begin
         s2_in.base = bprod[14:7];
         s2_in.inc  = s1_hinc_ff ? INC_HIGH : iprod[14:6];
      end
   end

   always_ff @(posedge clock) begin
      if (s1_v_ff && ready2) begin
         s2_ff <= s2_in;
      end
   end

   assign out_valid = s2_v_ff;
   assign out_data  = s2_ff;

endmodule

`default_nettype wire

// ===== rtl/core/nrrc_lane.sv =====
// One offset lane: the accumulator value after a fixed number of increments.
`default_nettype none

module nrrc_lane
   import nrrc_pkg::*;
#(
   parameter int LANE_INDEX = 0
)
(
   input  wire logic [7:0]       base,
   input  wire logic [INC_W-1:0] inc,
   output logic [7:0]            offset
);

   localparam int STEPS = (LANE_INDEX > 0) ? LANE_INDEX - 1 : 0;

   if (LANE_INDEX == 0) begin : g_base
      assign offset = base;
   end else begin : g_acc
      logic [15:0] acc0;
      logic [15:0] acc;

      // Lane 1 seeds the accumulator; later lanes add whole multiples of inc.
      assign acc0   = {base + {7'd0, inc[8]}, inc[7:0]};
      assign acc    = acc0 + ({7'd0, inc} * 16'(STEPS));
      assign offset = acc[15:8];
   end

endmodule

`default_nettype wire

// ===== rtl/core/nrrc_merge.sv =====
// Merge stage: maps lane offsets onto parts, saturating add, output register.
`default_nettype none

module nrrc_merge
   import nrrc_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          in_valid,
   output logic               in_ready,
   input  wire logic [3:0]    in_voice,
   input  wire part_arr_type  in_parts,
   input  wire off_arr_type   in_offsets,
   output logic               out_valid,
   input  wire logic          out_ready,
   output logic [3:0]         out_voice,
   output part_arr_type       out_speeds
);

   logic         v_ff, v_in;
   logic [3:0]   voice_ff;
   part_arr_type speed_ff, speed_in;
   logic [8:0]   sum [PART_COUNT];

   always_comb begin
      for (int p = 0; p < PART_COUNT; p++) begin
         sum[p]      = {1'b0, in_offsets[PART_SEL[p]]} + {1'b0, in_parts[p]};
         speed_in[p] = sum[p][8] ? 8'hFF : sum[p][7:0];
      end
   end

   assign in_ready = !v_ff || out_ready;
   assign v_in     = in_ready ? in_valid : v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         voice_ff <= in_voice;
         speed_ff <= speed_in;
      end
   end

   assign out_valid  = v_ff;
   assign out_voice  = voice_ff;
   assign out_speeds = speed_ff;

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the note release rate calculator.
`timescale 1ns / 1ps

module tb;

   // Fixed-point constants of the release speed arithmetic.
   localparam logic [7:0]  NOTE_BASE  = 8'h15;
   localparam logic [15:0] SCALE_MUL  = 16'h0076;
   localparam logic [15:0] STEP_MUL_A = 16'h0097;
   localparam logic [15:0] STEP_MUL_B = 16'h006D;
   localparam logic [7:0]  STEP_KNEE  = 8'h1B;
   localparam logic [15:0] STEP_HIGH  = 16'h00DB;

   localparam int PARTS           = 10;
   localparam int OFFSETS         = 8;
   localparam int IDLE_PCT        = 34;
   localparam int SETTLE_CYCLES   = 8;     // pipe is three stages deep
   localparam int ITEMS_PER_PHASE = 240;
   localparam int PHASES          = 7;
   localparam int CALM_PHASE      = 3;     // phase run with no idling on either side
   localparam int HOLD_AFTER      = 700;   // responses seen before the long rsp stall
   localparam int HOLD_CYCLES     = 300;

   typedef logic [PARTS-1:0][7:0] part_bytes_type;

   // One row of the directed table: either a release scale write or a
   // release transaction, optionally with its speeds typed in.
   typedef struct packed {
      logic           is_cfg;
      logic [7:0]     cfg_value;
      logic [3:0]     voice;
      logic [6:0]     note;
      part_bytes_type bases;
      logic           typed;
      part_bytes_type speeds;
   } stim_row_type;

   localparam int ROWS = 22;
   localparam part_bytes_type ALL_FF = {PARTS{8'hFF}};
   localparam part_bytes_type ALL_00 = {PARTS{8'h00}};
   localparam part_bytes_type MIXED  = 80'h13579BDF02468ACE1122;

   localparam stim_row_type DIRECTED [ROWS] = '{
      // release scale at its reset value: base term is zero
      '{1'b1, 8'h00, 4'd0,  7'd0,   ALL_00,                   1'b0, ALL_00},
      '{1'b0, 8'h00, 4'd0,  7'd0,   ALL_00,                   1'b1, ALL_00},
      '{1'b0, 8'h00, 4'd15, 7'd20,  ALL_FF,                   1'b1, ALL_FF},
      '{1'b0, 8'h00, 4'd5,  7'd21,  MIXED,                    1'b1, MIXED},
      '{1'b0, 8'h00, 4'd10, 7'd127, ALL_FF,                   1'b1, ALL_FF},
      '{1'b0, 8'h00, 4'd1,  7'd47,  ALL_00,                   1'b0, ALL_00},
      '{1'b0, 8'h00, 4'd2,  7'd48,  ALL_00,                   1'b0, ALL_00},
      '{1'b0, 8'h00, 4'd3,  7'd127, ALL_00,                   1'b0, ALL_00},
      // full-scale release scale
      '{1'b1, 8'hFF, 4'd0,  7'd0,   ALL_00,                   1'b0, ALL_00},
      '{1'b0, 8'h00, 4'd4,  7'd21,  ALL_00,                   1'b1, ALL_00},
      '{1'b0, 8'h00, 4'd6,  7'd127, ALL_00,                   1'b0, ALL_00},
      '{1'b0, 8'h00, 4'd7,  7'd48,  {PARTS{8'h80}},           1'b0, ALL_00},
      '{1'b0, 8'h00, 4'd8,  7'd20,  {PARTS{8'h5A}},           1'b1, {PARTS{8'h5A}}},
      '{1'b0, 8'h00, 4'd9,  7'd100, ALL_FF,                   1'b1, ALL_FF},
      '{1'b0, 8'h00, 4'd11, 7'd64,  {(PARTS/2){16'h00FF}},    1'b0, ALL_00},
      '{1'b0, 8'h00, 4'd12, 7'd22,  {PARTS{8'h01}},           1'b0, ALL_00},
      '{1'b1, 8'h80, 4'd0,  7'd0,   ALL_00,                   1'b0, ALL_00},
      '{1'b0, 8'h00, 4'd13, 7'd90,  {PARTS{8'h40}},           1'b0, ALL_00},
      '{1'b0, 8'h00, 4'd14, 7'd47,  {PARTS{8'hC0}},           1'b0, ALL_00},
      '{1'b1, 8'h01, 4'd0,  7'd0,   ALL_00,                   1'b0, ALL_00},
      '{1'b0, 8'h00, 4'd15, 7'd127, {PARTS{8'h7F}},           1'b0, ALL_00},
      '{1'b0, 8'h00, 4'd0,  7'd126, 80'hFEDCBA98765432100F1E, 1'b0, ALL_00}
   };

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic [95:0] req_tdata   = '0;
   logic        rsp_tready  = 1'b0;
   logic        csr_wr_en   = 1'b0;
   logic [7:0]  csr_wr_data = '0;
   wire         req_tready;
   wire         rsp_tvalid;
   wire  [87:0] rsp_tdata;

   // Expected rsp words, oldest first: {4'b0, speed9..speed0, voice}.
   logic [87:0] release_speed_q [$];
   logic [7:0]  rel_scale_shadow = 8'h00;
   bit          calm = 1'b0;
   int          rsp_seen   = 0;
   int          mismatches = 0;
   int          orphans    = 0;

   note_release_rate_calc_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Free-running 250 MHz clock.
   initial begin
      forever #2 clock = ~clock;
   end

   // Hold reset, then release it for good.
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   // Hard stop in case the pipe hangs.
   initial begin
      #2000000;
      $display("note_release_rate_calc_top test failed");
      $finish;
   end

   // Compute the rsp word for one release: eight note offsets from byte-wide
   // fixed-point math, parts 8 and 9 folded onto offset 0, saturating add.
   function automatic logic [87:0] release_speeds(input logic [3:0] voice,
                                                  input logic [6:0] note,
                                                  input part_bytes_type bases,
                                                  input logic [7:0] param);
      logic [OFFSETS-1:0][7:0] offs;
      logic [7:0]  nb;
      logic [7:0]  scale;
      logic [15:0] prod;
      logic [15:0] step;
      logic [15:0] acc;
      logic [8:0]  sum;
      logic [87:0] word;
      int          i;
      offs = '0;
      if ({1'b0, note} >= NOTE_BASE) begin
         nb    = {1'b0, note} - NOTE_BASE;
         prod  = SCALE_MUL * {8'h00, nb};
         prod  = prod << 2;
         prod  = {8'h00, prod[15:8]} * {8'h00, param};
         prod  = prod << 1;
         scale = prod[15:8];
         if (nb < STEP_KNEE) begin
            prod = STEP_MUL_A * {8'h00, nb};
            prod = prod << 3;
            prod = {8'h00, prod[15:8]} * STEP_MUL_B;
            step = prod >> 6;
         end else begin
            step = STEP_HIGH;
         end
         offs[0] = scale;
         offs[1] = step[15:8] + scale;
         acc     = {offs[1], step[7:0]};
         for (i = 2; i < OFFSETS; i++) begin
            acc     = acc + step;
            offs[i] = acc[15:8];
         end
      end
      word      = '0;
      word[3:0] = voice;
      for (i = 0; i < PARTS; i++) begin
         sum = {1'b0, offs[(i < OFFSETS) ? i : 0]} + {1'b0, bases[i]};
         word[4 + 8*i +: 8] = sum[8] ? 8'hFF : sum[7:0];
      end
      return word;
   endfunction

   // Offer one release transaction after a random gap; queue its expected
   // speeds once the handshake is certain. Enters and leaves on a rising edge.
   task automatic offer_release(input logic [95:0] word, input logic [87:0] speeds);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      // Inputs only move on rising edges, so tready at the falling edge
      // decides the coming edge.
      do @(negedge clock); while (!req_tready);
      release_speed_q.push_back(speeds);
      @(posedge clock);
   endtask

   // Stop offering and wait for the pipe to empty.
   task automatic drain_pipe;
      req_tvalid <= 1'b0;
      while (release_speed_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write the release scale; only called with the pipe empty.
   task automatic write_rel_scale(input logic [7:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      rel_scale_shadow = value;
   endtask

   // Pick a note: mostly the scaled range, some low notes, some edge notes.
   function automatic logic [6:0] pick_note();
      int r;
      r = $urandom_range(99);
      if (r < 15) return 7'($urandom_range(20));
      if (r < 25) begin
         case ($urandom_range(5))
            0:       return 7'd20;
            1:       return 7'd21;
            2:       return 7'd47;
            3:       return 7'd48;
            4:       return 7'd0;
            default: return 7'd127;
         endcase
      end
      return 7'($urandom_range(127, 21));
   endfunction

   // Pick a part base: mostly random, biased toward saturation and zero.
   function automatic logic [7:0] pick_base();
      int r;
      r = $urandom_range(99);
      if (r < 60) return 8'($urandom_range(255));
      if (r < 78) return 8'($urandom_range(255, 224));
      if (r < 88) return 8'h00;
      return 8'hFF;
   endfunction

   // Stimulus: directed table, then random phases across release scale values.
   initial begin
      stim_row_type   row;
      part_bytes_type bases;
      logic [3:0]     voice;
      logic [6:0]     note;
      logic [87:0]    speeds;
      logic [7:0]     phase_param;
      int             k;
      int             ph;
      int             n;
      int             p;

      while (reset) @(posedge clock);

      // Walk the directed table.
      for (k = 0; k < ROWS; k++) begin
         row = DIRECTED[k];
         if (row.is_cfg) begin
            drain_pipe();
            write_rel_scale(row.cfg_value);
         end else begin
            if (row.typed)
               speeds = {4'h0, row.speeds, row.voice};
            else
               speeds = release_speeds(row.voice, row.note, row.bases, rel_scale_shadow);
            offer_release({5'h00, row.bases, row.note, row.voice}, speeds);
         end
      end
      drain_pipe();

      // Random phases; each phase starts from an empty pipe.
      for (ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0:       phase_param = 8'h00;
            1:       phase_param = 8'hFF;
            2:       phase_param = 8'h01;
            3:       phase_param = 8'h80;
            default: phase_param = 8'($urandom_range(255));
         endcase
         write_rel_scale(phase_param);
         calm = (ph == CALM_PHASE);
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            voice = 4'($urandom_range(15));
            note  = pick_note();
            for (p = 0; p < PARTS; p++) bases[p] = pick_base();
            speeds = release_speeds(voice, note, bases, rel_scale_shadow);
            offer_release({5'h00, bases, note, voice}, speeds);
         end
         calm = 1'b0;
         drain_pipe();
      end

      if (mismatches == 0 && orphans == 0) begin
         $display("note_release_rate_calc_top test passed");
      end else begin
         $display("note_release_rate_calc_top test failed");
      end
      $finish;
   end

   // Response side: random back-pressure, plus one long stall that lets the
   // pipe fill and push back on req.
   initial begin
      bit held;
      held = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (!held && rsp_seen >= HOLD_AFTER) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // Log one field mismatch; report only the first few.
   task automatic flag_field(input string field, input logic [7:0] want,
                             input logic [7:0] got);
      if (mismatches < 10)
         $display("rsp mismatch on %s: expected %02h, got %02h", field, want, got);
      mismatches++;
   endtask

   // Check each rsp transaction against the oldest queued expectation.
   // Sampled on the falling edge, where both handshake sides are settled.
   always @(negedge clock) begin
      logic [87:0] want;
      int          p;
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_seen++;
         if (release_speed_q.size() == 0) begin
            if (mismatches + orphans < 10)
               $display("rsp transaction with nothing pending: %022h", rsp_tdata);
            orphans++;
         end else begin
            want = release_speed_q.pop_front();
            if (rsp_tdata[3:0] !== want[3:0])
               flag_field("voice_out", {4'h0, want[3:0]}, {4'h0, rsp_tdata[3:0]});
            for (p = 0; p < PARTS; p++) begin
               if (rsp_tdata[4 + 8*p +: 8] !== want[4 + 8*p +: 8])
                  flag_field($sformatf("speed%0d", p), want[4 + 8*p +: 8],
                             rsp_tdata[4 + 8*p +: 8]);
            end
         end
      end
   end

endmodule
